// ===== rtl/skpl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skpl_pkg
// Shared types and constants for the scale and keyboard-map pitch lookup.
// ----------------------------------------------------------------------------
package skpl_pkg;

    localparam int SCALE_DEPTH_DEF  = 128;
    localparam int MAP_DEPTH_DEF    = 128;
    localparam int TABLE_SIZE_DEF   = 256;
    localparam int TABLE_CENTER_DEF = 128;

    localparam int CONST_NOTE = 60;
    localparam int FRAC_BITS  = 16;

    // Map length and modulus width; map_length is an 8-bit register.
    localparam int M_W = 8;

    localparam logic [1:0] REQ_SCALE_WR = 2'd0;
    localparam logic [1:0] REQ_MAP_WR   = 2'd1;
    localparam logic [1:0] REQ_CONVERT  = 2'd2;

    localparam logic [1:0] CFG_SCALE_STEPS = 2'd0;
    localparam logic [1:0] CFG_MAP_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_START_NOTE  = 2'd2;
    localparam logic [1:0] CFG_REF_OFFSET  = 2'd3;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_POS = 2'd1,
        STAT_MAP = 2'd2,
        STAT_SAT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_FIX,
        ST_MAPRD,
        ST_DEG,
        ST_ADD1,
        ST_ADD2,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/skpl_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skpl_divider
// Restoring unsigned divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module skpl_divider #(
    parameter int N_W = 10,
    parameter int D_W = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient,
    output logic [D_W-1:0] remainder
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [D_W:0]     rem_sh;
    logic             ge;

    // The partial remainder stays below the divisor, so the shifted value
    // fits in one extra bit.
    always_comb begin
        rem_sh = {rem_reg, quo_reg[N_W-1]};
        ge     = (rem_sh >= {1'b0, divisor});
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(N_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? D_W'(rem_sh - {1'b0, divisor}) : D_W'(rem_sh);
            quo_next = {quo_reg[N_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/scale_keymap_pitch_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scale_keymap_pitch_lookup
// Maps MIDI notes to microtuned Q15.16 pitches from a scale and keyboard map.
// ----------------------------------------------------------------------------
// One word is taken at a time. Scale writes, map writes and unused request
// kinds go straight from accept to the result stage, and so does a conversion
// under constant tuning. In a full conversion the serial divider splits the
// magnitude of the clamped key position (P_W bits wide) by the map length or
// step count, producing one quotient bit per cycle, and the two memories are
// then read in turn before a multiply and two adds. After reset a clearing
// pass loads the default equal-tempered degrees into every scale entry, and no
// word is taken until it ends; configuration writes are taken at any time.
module scale_keymap_pitch_lookup
    import skpl_pkg::*;
#(
    parameter int SCALE_DEPTH  = SCALE_DEPTH_DEF,
    parameter int MAP_DEPTH    = MAP_DEPTH_DEF,
    parameter int TABLE_SIZE   = TABLE_SIZE_DEF,
    parameter int TABLE_CENTER = TABLE_CENTER_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // Requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // entry_index[6:0], entry_value[38:7], note[45:39]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pitch[31:0]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int SCALE_AW = $clog2(SCALE_DEPTH);
    localparam int MAP_AW   = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int P_W      = $clog2(TABLE_SIZE + TABLE_CENTER + 128) + 1;
    localparam int ACC_W    = P_W + 34;

    localparam logic signed [P_W-1:0]   P_LO   = P_W'(-TABLE_CENTER);
    localparam logic signed [P_W-1:0]   P_HI   = P_W'(TABLE_SIZE - 1 - TABLE_CENTER);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    // Configuration registers
    logic [6:0]         steps_cfg_reg;
    logic [7:0]         map_len_cfg_reg;
    logic [6:0]         start_cfg_reg;
    logic signed [31:0] ref_cfg_reg;

    // Request fields
    logic [1:0]         in_req;
    logic [6:0]         in_index;
    logic [31:0]        in_value;
    logic [6:0]         in_note;

    state_t state_reg, state_next;

    logic               accept;
    logic               out_free;

    // Values formed at accept
    logic [6:0]         steps_cur;
    logic [M_W-1:0]     mlen_cur;
    logic [M_W-1:0]     m_cur;
    logic signed [P_W-1:0] p_raw, p_cl;
    logic               pos_cur;
    logic [P_W-1:0]     p_mag;
    logic signed [ACC_W-1:0] base_cur;

    // Work registers
    logic [6:0]         steps_reg;
    logic               mlen_nz_reg;
    logic [M_W-1:0]     m_reg;
    logic               p_neg_reg;
    logic signed [ACC_W-1:0] base_reg;
    logic               pos_reg;
    logic               map_flag_reg;
    logic signed [P_W-1:0] q_reg, q_next;
    logic [M_W-1:0]     r_reg, r_next;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [P_W+31:0]  prod;
    logic [6:0]         deg_cur;
    logic               map_hit;

    // Divider
    logic               div_start;
    logic               div_done;
    logic [P_W-1:0]     div_quo;
    logic [M_W-1:0]     div_rem;

    // Scale memory
    logic signed [31:0] scale_mem [SCALE_DEPTH];
    logic               sc_we;
    logic [SCALE_AW-1:0] sc_waddr, sc_raddr;
    logic signed [31:0] sc_wdata;
    logic signed [31:0] scale_rd_reg;
    logic [SCALE_AW-1:0] clr_addr_reg;

    // Map memory
    logic [6:0]         map_mem [MAP_DEPTH];
    logic               map_we;
    logic [MAP_AW-1:0]  map_waddr, map_raddr;
    logic [6:0]         map_rd_reg;

    // Output stage
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;
    logic [31:0]        pitch_out;
    status_t            status_out;

    assign in_req   = s_tuser;
    assign in_index = s_tdata[6:0];
    assign in_value = s_tdata[38:7];
    assign in_note  = s_tdata[45:39];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_cfg_reg   <= 7'd12;
            map_len_cfg_reg <= 8'd0;
            start_cfg_reg   <= 7'd60;
            ref_cfg_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SCALE_STEPS: steps_cfg_reg   <= cfg_wdata[6:0];
                CFG_MAP_LENGTH:  map_len_cfg_reg <= cfg_wdata[7:0];
                CFG_START_NOTE:  start_cfg_reg   <= cfg_wdata[6:0];
                CFG_REF_OFFSET:  ref_cfg_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request decode at accept
    // ------------------------------------------------------------------
    always_comb begin
        if (32'(steps_cfg_reg) > 32'(SCALE_DEPTH - 1)) begin
            steps_cur = 7'(SCALE_DEPTH - 1);
        end else begin
            steps_cur = steps_cfg_reg;
        end
        if (32'(map_len_cfg_reg) > 32'(MAP_DEPTH)) begin
            mlen_cur = M_W'(MAP_DEPTH);
        end else begin
            mlen_cur = map_len_cfg_reg;
        end
        m_cur = (mlen_cur != '0) ? mlen_cur : M_W'(steps_cur);

        p_raw   = $signed(P_W'(in_note)) - $signed(P_W'(start_cfg_reg));
        p_cl    = p_raw;
        pos_cur = 1'b0;
        if (p_raw < P_LO) begin
            p_cl    = P_LO;
            pos_cur = 1'b1;
        end
        if (p_raw > P_HI) begin
            p_cl    = P_HI;
            pos_cur = 1'b1;
        end
        p_mag = p_cl[P_W-1] ? P_W'(-p_cl) : P_W'(p_cl);

        base_cur = ACC_W'($signed({1'b0, start_cfg_reg, 16'h0000})) + ACC_W'(ref_cfg_reg);
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == SCALE_AW'(SCALE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (in_req == REQ_CONVERT && steps_cur != 7'd0) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:   state_next = ST_MAPRD;
            ST_MAPRD: state_next = ST_DEG;
            ST_DEG:   state_next = ST_ADD1;
            ST_ADD1:  state_next = ST_ADD2;
            ST_ADD2:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        sc_we     = 1'b0;
        sc_waddr  = clr_addr_reg;
        sc_wdata  = 32'(clr_addr_reg) << FRAC_BITS;
        sc_raddr  = SCALE_AW'(steps_reg);
        map_we    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                sc_we = 1'b1;
            end
            ST_IDLE: begin
                if (accept) begin
                    div_start = (in_req == REQ_CONVERT) && (steps_cur != 7'd0);
                    if (in_req == REQ_SCALE_WR && 32'(in_index) < 32'(SCALE_DEPTH)) begin
                        sc_we    = 1'b1;
                        sc_waddr = SCALE_AW'(in_index);
                        sc_wdata = in_value;
                    end
                    map_we = (in_req == REQ_MAP_WR) && (32'(in_index) < 32'(MAP_DEPTH));
                end
            end
            ST_DEG: begin
                sc_raddr = SCALE_AW'(deg_cur);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared divider: |p| by the map length or the step count
    // ------------------------------------------------------------------
    skpl_divider #(
        .N_W (P_W),
        .D_W (M_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (p_mag),
        .divisor   (m_cur),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Turn the truncated magnitude result into a floored quotient and a
    // non-negative remainder.
    always_comb begin
        q_next = $signed(div_quo);
        r_next = div_rem;
        if (p_neg_reg) begin
            if (div_rem != '0) begin
                q_next = -$signed(div_quo) - P_W'(1);
                r_next = m_reg - div_rem;
            end else begin
                q_next = -$signed(div_quo);
            end
        end
    end

    // A map target above the step count falls back to the period entry.
    always_comb begin
        map_hit = 1'b0;
        deg_cur = r_reg[6:0];
        if (mlen_nz_reg) begin
            if (map_rd_reg > steps_reg) begin
                deg_cur = steps_reg;
                map_hit = 1'b1;
            end else begin
                deg_cur = map_rd_reg;
            end
        end
    end

    assign prod      = q_reg * scale_rd_reg;
    assign map_raddr = MAP_AW'(r_reg);

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    steps_reg    <= steps_cur;
                    mlen_nz_reg  <= (mlen_cur != '0);
                    m_reg        <= m_cur;
                    p_neg_reg    <= p_cl[P_W-1];
                    base_reg     <= base_cur;
                    map_flag_reg <= 1'b0;
                    if (in_req == REQ_CONVERT) begin
                        // Constant tuning ignores the position clamp.
                        pos_reg <= pos_cur && (steps_cur != 7'd0);
                        acc_reg <= base_cur + (ACC_W'(CONST_NOTE) <<< FRAC_BITS);
                    end else begin
                        pos_reg <= 1'b0;
                        acc_reg <= '0;
                    end
                end
            end
            ST_FIX: begin
                q_reg <= q_next;
                r_reg <= r_next;
            end
            ST_DEG: begin
                map_flag_reg <= map_hit;
                prod_reg     <= ACC_W'(prod);
            end
            ST_ADD1: begin
                acc_reg <= prod_reg + ACC_W'(scale_rd_reg);
            end
            ST_ADD2: begin
                acc_reg <= acc_reg + base_reg;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (sc_we) begin
            scale_mem[sc_waddr] <= sc_wdata;
        end
        scale_rd_reg <= scale_mem[sc_raddr];
    end

    assign map_waddr = MAP_AW'(in_index);

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= in_value[6:0];
        end
        map_rd_reg <= map_mem[map_raddr];
    end

    // ------------------------------------------------------------------
    // Saturation and output register
    // ------------------------------------------------------------------
    always_comb begin
        pitch_out = acc_reg[31:0];
        if (map_flag_reg) begin
            status_out = STAT_MAP;
        end else if (pos_reg) begin
            status_out = STAT_POS;
        end else begin
            status_out = STAT_OK;
        end
        if (acc_reg > SAT_HI) begin
            pitch_out  = 32'h7FFF_FFFF;
            status_out = STAT_SAT;
        end else if (acc_reg < SAT_LO) begin
            pitch_out  = 32'h8000_0000;
            status_out = STAT_SAT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= pitch_out;
            m_tuser_reg <= status_out;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== bench/tb_scale_keymap_pitch_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scale_keymap_pitch_lookup
// Self-checking bench for the scale and keyboard-map pitch lookup. A table of
// directed words covers the reset tuning, saturation both ways, map target
// clamping, constant tuning and the unused request kind. Random phases then
// sweep the registers and the idling of both stream sides. Each result is checked
// against its directed row's typed value, or else a behavioral lookup model in the bench.
// ----------------------------------------------------------------------------
module tb_scale_keymap_pitch_lookup;
    import skpl_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int     RAND_PHASES   = 12;
    localparam int     PHASE_WORDS   = 126;
    localparam int     DRAIN_CYCLES  = 40;
    localparam int     CYCLE_LIMIT   = 1000000;
    localparam int     MAX_REPORTS   = 40;
    localparam int     DIRECTED_ROWS = 32;
    localparam longint ONE_SEMITONE  = 64'sd1 << FRAC_BITS;
    localparam longint PITCH_MAX     = 64'sd2147483647;
    localparam longint PITCH_MIN     = -64'sd2147483648;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_SCALE_STEPS;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;   // entry_index[6:0], entry_value[38:7], note[45:39]
    logic [1:0]  s_tuser   = REQ_SCALE_WR;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;   // pitch[31:0]
    logic [1:0]  m_tuser;   // status[1:0]

    scale_keymap_pitch_lookup dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    typedef struct {
        logic [31:0] pitch;
        status_t     status;
        logic [1:0]  req;
        logic [6:0]  key;
    } pitch_result_t;

    typedef struct packed {
        logic        is_reg;
        logic [1:0]  code;
        logic [6:0]  idx;
        logic [31:0] value;
        logic [6:0]  key;
        logic        typed;
        logic [31:0] pitch;
        status_t     status;
    } directed_row_t;

    pitch_result_t expected_pitches [$];

    // Shadow of the tuning registers and stores.
    logic [6:0]         reg_steps;
    logic [7:0]         reg_map_len;
    logic [6:0]         reg_start;
    logic signed [31:0] reg_ofs;
    logic signed [31:0] scale_deg [SCALE_DEPTH_DEF];
    logic [6:0]         key_map [MAP_DEPTH_DEF];
    bit                 key_map_set [MAP_DEPTH_DEF];

    // Idle pattern: 0 none, 1 sender, 2 receiver, 3 both.
    int          idle_mode = 0;
    int unsigned send_idle_pct [4] = '{0, 86, 0, 8};
    int unsigned recv_stall_pct [4] = '{0, 0, 86, 8};

    int unsigned cycle_count = 0;
    int          err_count = 0;
    int          words_sent = 0;
    int          results_seen = 0;
    int          sat_seen = 0;
    int          map_clamp_seen = 0;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, REQ_CONVERT,  7'd0,   32'h00000000, 7'd60,  1'b1, 32'h003C0000, STAT_OK},
        '{1'b0, REQ_CONVERT,  7'd0,   32'h00000000, 7'd0,   1'b1, 32'h00000000, STAT_OK},
        '{1'b0, REQ_CONVERT,  7'd0,   32'h00000000, 7'd127, 1'b1, 32'h007F0000, STAT_OK},
        '{1'b0, REQ_SCALE_WR, 7'd0,   32'h7FFFFFFF, 7'd127, 1'b1, 32'h00000000, STAT_OK},
        '{1'b0, REQ_CONVERT,  7'd0,   32'h00000000, 7'd60,  1'b1, 32'h7FFFFFFF, STAT_SAT},
        '{1'b0, REQ_SCALE_WR, 7'd0,   32'h80000000, 7'd0,   1'b1, 32'h00000000, STAT_OK},
        '{1'b0, REQ_CONVERT,  7'd0,   32'h00000000, 7'd60,  1'b0, 32'h00000000, STAT_OK},
        '{1'b0, REQ_CONVERT,  7'd0,   32'h00000000, 7'd0,   1'b0, 32'h00000000, STAT_OK},
        '{1'b0, REQ_SCALE_WR, 7'd12,  32'h80000000, 7'd0,   1'b1, 32'h00000000, STAT_OK},
        '{1'b0, REQ_CONVERT,  7'd0,   32'h00000000, 7'd0,   1'b1, 32'h7FFFFFFF, STAT_SAT},
        '{1'b0, REQ_CONVERT,  7'd0,   32'h00000000, 7'd127, 1'b1, 32'h80000000, STAT_SAT},
        '{1'b0, REQ_SCALE_WR, 7'd0,   32'h00000000, 7'd0,   1'b1, 32'h00000000, STAT_OK},
        '{1'b0, REQ_SCALE_WR, 7'd12,  32'h000C0000, 7'd0,   1'b1, 32'h00000000, STAT_OK},
        '{1'b0, REQ_MAP_WR,   7'd127, 32'hFFFFFFFF, 7'd0,   1'b1, 32'h00000000, STAT_OK},
        '{1'b0, REQ_MAP_WR,   7'd0,   32'hFFFFFF85, 7'd0,   1'b1, 32'h00000000, STAT_OK},
        '{1'b0, REQ_UNUSED,   7'd127, 32'hFFFFFFFF, 7'd127, 1'b1, 32'h00000000, STAT_OK},
        '{1'b1, CFG_MAP_LENGTH,  7'd0, 32'd1,        7'd0,   1'b0, 32'h00000000, STAT_OK},
        '{1'b0, REQ_CONVERT,  7'd0,   32'h00000000, 7'd61,  1'b1, 32'h004D0000, STAT_OK},
        '{1'b0, REQ_MAP_WR,   7'd0,   32'd100,      7'd0,   1'b1, 32'h00000000, STAT_OK},
        '{1'b0, REQ_CONVERT,  7'd0,   32'h00000000, 7'd60,  1'b1, 32'h00480000, STAT_MAP},
        '{1'b1, CFG_SCALE_STEPS, 7'd0, 32'd0,        7'd0,   1'b0, 32'h00000000, STAT_OK},
        '{1'b0, REQ_CONVERT,  7'd0,   32'h00000000, 7'd0,   1'b1, 32'h00780000, STAT_OK},
        '{1'b1, CFG_REF_OFFSET,  7'd0, 32'h7FFFFFFF, 7'd0,   1'b0, 32'h00000000, STAT_OK},
        '{1'b0, REQ_CONVERT,  7'd0,   32'h00000000, 7'd127, 1'b1, 32'h7FFFFFFF, STAT_SAT},
        '{1'b1, CFG_REF_OFFSET,  7'd0, 32'h80000000, 7'd0,   1'b0, 32'h00000000, STAT_OK},
        '{1'b0, REQ_CONVERT,  7'd0,   32'h00000000, 7'd5,   1'b0, 32'h00000000, STAT_OK},
        '{1'b1, CFG_SCALE_STEPS, 7'd0, 32'd127,      7'd0,   1'b0, 32'h00000000, STAT_OK},
        '{1'b1, CFG_MAP_LENGTH,  7'd0, 32'd0,        7'd0,   1'b0, 32'h00000000, STAT_OK},
        '{1'b1, CFG_START_NOTE,  7'd0, 32'd0,        7'd0,   1'b0, 32'h00000000, STAT_OK},
        '{1'b1, CFG_REF_OFFSET,  7'd0, 32'd0,        7'd0,   1'b0, 32'h00000000, STAT_OK},
        '{1'b0, REQ_CONVERT,  7'd0,   32'h00000000, 7'd127, 1'b1, 32'h007F0000, STAT_OK},
        '{1'b0, REQ_CONVERT,  7'd0,   32'h00000000, 7'd0,   1'b1, 32'h00000000, STAT_OK}
    };

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // Applies one accepted word to the shadow stores and returns its result.
    function automatic pitch_result_t tune_word(input logic [1:0] req, input logic [6:0] idx,
                                                input logic [31:0] value, input logic [6:0] key);
        pitch_result_t res;
        int            steps;
        int            mlen;
        int            modulus;
        int            pos;
        int            quot;
        int            rem;
        int            deg;
        longint        acc;
        res.pitch  = '0;
        res.status = STAT_OK;
        res.req    = req;
        res.key    = key;
        if (req == REQ_SCALE_WR) begin
            scale_deg[idx] = value;
        end else if (req == REQ_MAP_WR) begin
            key_map[idx]     = value[6:0];
            key_map_set[idx] = 1'b1;
        end else if (req == REQ_CONVERT) begin
            steps = int'(reg_steps);
            if (steps > SCALE_DEPTH_DEF - 1)
                steps = SCALE_DEPTH_DEF - 1;
            acc = longint'(reg_start) * ONE_SEMITONE + longint'(reg_ofs);
            if (steps == 0) begin
                acc += longint'(CONST_NOTE) * ONE_SEMITONE;
            end else begin
                mlen = int'(reg_map_len);
                if (mlen > MAP_DEPTH_DEF)
                    mlen = MAP_DEPTH_DEF;
                modulus = (mlen != 0) ? mlen : steps;
                pos = int'(key) - int'(reg_start);
                if (pos < -TABLE_CENTER_DEF) begin
                    pos = -TABLE_CENTER_DEF;
                    res.status = STAT_POS;
                end
                if (pos > TABLE_SIZE_DEF - 1 - TABLE_CENTER_DEF) begin
                    pos = TABLE_SIZE_DEF - 1 - TABLE_CENTER_DEF;
                    res.status = STAT_POS;
                end
                // Floor division: the remainder must land inside the map.
                quot = pos / modulus;
                rem  = pos % modulus;
                if (rem < 0) begin
                    rem  += modulus;
                    quot -= 1;
                end
                if (mlen != 0) begin
                    deg = int'(key_map[rem]);
                    if (deg > steps) begin
                        deg = steps;
                        res.status = STAT_MAP;
                    end
                end else begin
                    deg = rem;
                end
                acc += longint'(quot) * longint'(scale_deg[steps]) + longint'(scale_deg[deg]);
            end
            if (acc > PITCH_MAX) begin
                acc = PITCH_MAX;
                res.status = STAT_SAT;
            end
            if (acc < PITCH_MIN) begin
                acc = PITCH_MIN;
                res.status = STAT_SAT;
            end
            res.pitch = acc[31:0];
        end
        return res;
    endfunction

    task automatic send_word(input logic [1:0] req, input logic [6:0] idx,
                             input logic [31:0] value, input logic [6:0] key,
                             input logic typed, input logic [31:0] typed_pitch,
                             input status_t typed_status);
        pitch_result_t res;
        while ($urandom_range(1, 100) <= send_idle_pct[idle_mode]) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, key, value, idx};
        s_tuser  <= req;
        do @(posedge aclk); while (!s_tready);
        res = tune_word(req, idx, value, key);
        if (typed) begin
            res.pitch  = typed_pitch;
            res.status = typed_status;
        end
        expected_pitches = {expected_pitches, res};
        words_sent++;
    endtask

    // Holds the sender off until every outstanding result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_pitches.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        case (index)
            CFG_SCALE_STEPS: reg_steps   = value[6:0];
            CFG_MAP_LENGTH:  reg_map_len = value[7:0];
            CFG_START_NOTE:  reg_start   = value[6:0];
            default:         reg_ofs     = value;
        endcase
    endtask

    function automatic logic [31:0] small_offset();
        return 32'($urandom_range(0, 32'h00FFFFFF)) - 32'h00800000;
    endfunction

    task automatic run_phase(input int phase);
        logic [6:0]  steps;
        logic [7:0]  mlen;
        logic [6:0]  start;
        logic [31:0] ofs;
        logic [6:0]  idx;
        logic [6:0]  key;
        logic [31:0] value;
        int          eff_len;
        int          count;
        int          roll;
        case (phase)
            0: begin steps = 7'd12;  mlen = 8'd0;   start = 7'd60;  ofs = 32'd0;        end
            1: begin steps = 7'd127; mlen = 8'd128; start = 7'd0;   ofs = 32'h7FFFFFFF; end
            2: begin steps = 7'd1;   mlen = 8'd255; start = 7'd127; ofs = 32'h80000000; end
            3: begin steps = 7'd0;   mlen = 8'd1;   start = 7'd127; ofs = $urandom;     end
            4: begin steps = 7'd7;   mlen = 8'd12;  start = 7'd60;  ofs = small_offset(); end
            5: begin steps = 7'd127; mlen = 8'd0;   start = 7'd127; ofs = 32'd0;        end
            default: begin
                steps = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                    : 7'($urandom_range(1, 24));
                roll = $urandom_range(0, 9);
                if (roll < 4)
                    mlen = 8'd0;
                else if (roll < 8)
                    mlen = 8'($urandom_range(1, 24));
                else if (roll == 8)
                    mlen = 8'd128;
                else
                    mlen = 8'($urandom_range(129, 255));
                start = 7'($urandom_range(0, 127));
                ofs = ($urandom_range(0, 3) == 0) ? 32'($urandom) : small_offset();
            end
        endcase

        drain_results();
        write_reg(CFG_SCALE_STEPS, 32'(steps));
        write_reg(CFG_MAP_LENGTH, 32'(mlen));
        write_reg(CFG_START_NOTE, 32'(start));
        write_reg(CFG_REF_OFFSET, ofs);
        cfg_wr_en <= 1'b0;
        idle_mode = phase % 4;

        eff_len = (int'(mlen) > MAP_DEPTH_DEF) ? MAP_DEPTH_DEF : int'(mlen);
        count = 0;

        // Every map entry a conversion can reach must hold a written target.
        for (int i = 0; i < eff_len; i++) begin
            if (!key_map_set[i]) begin
                value = {25'($urandom), 7'($urandom_range(0, int'(steps)))};
                send_word(REQ_MAP_WR, 7'(i), value, 7'($urandom), 1'b0, '0, STAT_OK);
                count++;
            end
        end

        while (count < PHASE_WORDS) begin
            roll  = $urandom_range(0, 99);
            idx   = 7'($urandom);
            key   = 7'($urandom);
            value = $urandom;
            if (roll < 55) begin
                send_word(REQ_CONVERT, idx, value, key, 1'b0, '0, STAT_OK);
                count++;
            end else if (roll < 72) begin
                if ($urandom_range(0, 1) == 0)
                    idx = 7'($urandom_range(0, int'(steps)));
                if ($urandom_range(0, 9) < 7)
                    value = small_offset();
                send_word(REQ_SCALE_WR, idx, value, key, 1'b0, '0, STAT_OK);
                count++;
            end else if (roll < 90) begin
                if (eff_len != 0 && $urandom_range(0, 1) == 0)
                    idx = 7'($urandom_range(0, eff_len - 1));
                if ($urandom_range(0, 9) < 7)
                    value[6:0] = 7'($urandom_range(0, int'(steps)));
                send_word(REQ_MAP_WR, idx, value, key, 1'b0, '0, STAT_OK);
                count++;
            end else if (roll < 97) begin
                send_word(REQ_UNUSED, idx, value, key, 1'b0, '0, STAT_OK);
            end else begin
                drain_results();
            end
        end
    endtask

    always @(posedge aclk) begin
        pitch_result_t want;
        m_tready <= ($urandom_range(1, 100) > recv_stall_pct[idle_mode]);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pitches.size() == 0) begin
                report_mismatch($sformatf("unexpected result: pitch %h status %0d",
                                          m_tdata, m_tuser));
            end else begin
                want = expected_pitches.pop_front();
                results_seen++;
                if (m_tdata !== want.pitch)
                    report_mismatch($sformatf("req %0d note %0d: pitch %h, expected %h",
                                              want.req, want.key, m_tdata, want.pitch));
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("req %0d note %0d: status %0d, expected %0d",
                                              want.req, want.key, m_tuser, want.status));
                if (want.status == STAT_SAT)
                    sat_seen++;
                if (want.status == STAT_MAP)
                    map_clamp_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_pitches.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        directed_row_t row;
        reg_steps   = 7'd12;
        reg_map_len = 8'd0;
        reg_start   = 7'd60;
        reg_ofs     = '0;
        for (int j = 0; j < SCALE_DEPTH_DEF; j++)
            scale_deg[j] = 32'(j) << FRAC_BITS;
        for (int j = 0; j < MAP_DEPTH_DEF; j++) begin
            key_map[j]     = '0;
            key_map_set[j] = 1'b0;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_rows[i];
            if (row.is_reg) begin
                drain_results();
                write_reg(row.code, row.value);
                cfg_wr_en <= 1'b0;
            end else begin
                send_word(row.code, row.idx, row.value, row.key, row.typed, row.pitch,
                          row.status);
            end
        end

        for (int k = 0; k < RAND_PHASES; k++)
            run_phase(k);

        s_tvalid <= 1'b0;
        while (expected_pitches.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d words over %0d register settings; %0d results compared.",
                 words_sent, RAND_PHASES + 1, results_seen);
        $display("Saturated pitches %0d, clamped map targets %0d; %0d mismatches.",
                 sat_seen, map_clamp_seen, err_count);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
